/* rtl/core/pmsr_pkg.sv */
// Shared types and constants for the single-read PCI initiator.
package pmsr_pkg;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_ADDR       = 4'd1,
        PH_TURN       = 4'd2,
        PH_DEVSEL     = 4'd3,
        PH_TRDY       = 4'd4,
        PH_END_MASTER = 4'd5,
        PH_END_TRDY   = 4'd6,
        PH_END_TARGET = 4'd7,
        PH_END_RETRY  = 4'd8,
        PH_DATA1      = 4'd9,
        PH_DATA_OK    = 4'd10,
        PH_DATA_BAD   = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_MASTER = 3'd1,
        ST_TRDY   = 3'd2,
        ST_TARGET = 3'd3,
        ST_RETRY  = 3'd4,
        ST_PARITY = 3'd5,
        ST_PROTO  = 3'd6
    } t_status;

    typedef enum logic {
        REG_DEVSEL_TIMEOUT = 1'b0,
        REG_TRDY_TIMEOUT   = 1'b1
    } t_reg_idx;

    localparam logic [31:0] ALL_ONES           = 32'hffff_ffff;
    localparam logic [3:0]  DEVSEL_TIMEOUT_RST = 4'd4;
    localparam logic [7:0]  TRDY_TIMEOUT_RST   = 8'd12;

    typedef struct packed {
        logic        start_req;
        logic [31:0] address;
        logic [3:0]  command;
        logic [3:0]  byte_enables;
        logic        devsel_in;
        logic        trdy_in;
        logic        stop_in;
        logic        frame_in;
        logic        irdy_in;
        logic [31:0] ad_in;
        logic        par_in;
    } t_sample;

    typedef struct packed {
        logic        frame_out;
        logic        irdy_out;
        logic        idsel_out;
        logic        ad_enable;
        logic [31:0] ad_out;
        logic        cbe_enable;
        logic [3:0]  cbe_out;
        logic        par_enable;
        logic        par_out;
        logic        done_res;
        t_status     status;
        logic [31:0] read_data;
    } t_result;

endpackage

/* rtl/core/pci_master_single_read.sv */
// Top level of the single-data-phase PCI read initiator with its register port and output queue.
//
// Each input word is one PCI bus clock: a start request with address, command and
// byte enables, plus the sampled DEVSEL, TRDY, STOP, FRAME, IRDY, AD and PAR pins.
// Every accepted input word yields exactly one output word holding the pin drives
// for that clock and, when a transaction ends, done_res with a status and read data.
// The result of a word is computed in the cycle it is accepted and is registered in the
// output queue before it is offered on the output channel, so one word can be accepted
// every cycle while o_in_stall is low. A two-entry output queue holds results while the
// receiver stalls; o_in_stall rises only when both entries are full, and is a
// register output. Reset empties the queue, returns the sequencer to idle and
// loads the DEVSEL timeout with 4 and the TRDY timeout with 12. The user must write the timeouts
// at APB byte addresses 0 and 4 only while the block is idle; the block does not enforce this.
module pci_master_single_read (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_req,
    input  logic [31:0] i_address,
    input  logic [3:0]  i_command,
    input  logic [3:0]  i_byte_enables,
    input  logic        i_devsel_in,
    input  logic        i_trdy_in,
    input  logic        i_stop_in,
    input  logic        i_frame_in,
    input  logic        i_irdy_in,
    input  logic [31:0] i_ad_in,
    input  logic        i_par_in,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_out,
    output logic        o_irdy_out,
    output logic        o_idsel_out,
    output logic        o_ad_enable,
    output logic [31:0] o_ad_out,
    output logic        o_cbe_enable,
    output logic [3:0]  o_cbe_out,
    output logic        o_par_enable,
    output logic        o_par_out,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [31:0] o_read_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pmsr_pkg::*;

    logic [3:0] r_devsel_timeout;
    logic [7:0] r_trdy_timeout;
    logic       cfg_wr;
    t_reg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_devsel_timeout <= DEVSEL_TIMEOUT_RST;
            r_trdy_timeout   <= TRDY_TIMEOUT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEVSEL_TIMEOUT: r_devsel_timeout <= pwdata[3:0];
                REG_TRDY_TIMEOUT:   r_trdy_timeout   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_DEVSEL_TIMEOUT: prdata = {28'd0, r_devsel_timeout};
            REG_TRDY_TIMEOUT:   prdata = {24'd0, r_trdy_timeout};
            default:            prdata = '0;
        endcase
    end

    // Sequencer
    logic    in_acc;
    logic    out_acc;
    t_sample sample;
    t_result step_res;

    assign sample.start_req    = i_start_req;
    assign sample.address      = i_address;
    assign sample.command      = i_command;
    assign sample.byte_enables = i_byte_enables;
    assign sample.devsel_in    = i_devsel_in;
    assign sample.trdy_in      = i_trdy_in;
    assign sample.stop_in      = i_stop_in;
    assign sample.frame_in     = i_frame_in;
    assign sample.irdy_in      = i_irdy_in;
    assign sample.ad_in        = i_ad_in;
    assign sample.par_in       = i_par_in;

    pmsr_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_acc),
        .i_devsel_timeout (r_devsel_timeout),
        .i_trdy_timeout   (r_trdy_timeout),
        .i_sample         (sample),
        .o_result         (step_res)
    );

    // Two-entry output queue
    t_result    r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_in_stall  = r_count[1];
    assign o_out_valid = (r_count != 2'd0);
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_acc     = o_out_valid & ~i_out_stall;

    always_comb begin
        n_count = r_count;
        if (in_acc && !out_acc) begin
            n_count = r_count + 2'd1;
        end else if (out_acc && !in_acc) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (in_acc) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_acc) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_queue[r_wr_ptr] <= step_res;
        end
    end

    t_result head;
    assign head = r_queue[r_rd_ptr];

    assign o_frame_out  = head.frame_out;
    assign o_irdy_out   = head.irdy_out;
    assign o_idsel_out  = head.idsel_out;
    assign o_ad_enable  = head.ad_enable;
    assign o_ad_out     = head.ad_out;
    assign o_cbe_enable = head.cbe_enable;
    assign o_cbe_out    = head.cbe_out;
    assign o_par_enable = head.par_enable;
    assign o_par_out    = head.par_out;
    assign o_done_res   = head.done_res;
    assign o_status     = head.status;
    assign o_read_data  = head.read_data;

endmodule

/* rtl/core/pmsr_seq.sv */
// Bus phase sequencer: drives the pins for the current phase and advances on each sampled clock.
module pmsr_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [3:0]        i_devsel_timeout,
    input  logic [7:0]        i_trdy_timeout,
    input  pmsr_pkg::t_sample i_sample,
    output pmsr_pkg::t_result o_result
);
    import pmsr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_wait, n_wait;
    logic [31:0] r_address, n_address;
    logic [3:0]  r_command, n_command;
    logic [3:0]  r_bes, n_bes;
    logic [31:0] r_data, n_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_wait    <= '0;
            r_address <= '0;
            r_command <= '0;
            r_bes     <= '0;
            r_data    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_wait    <= n_wait;
            r_address <= n_address;
            r_command <= n_command;
            r_bes     <= n_bes;
            r_data    <= n_data;
        end
    end

    always_comb begin
        logic [7:0] td_cnt;
        logic       exp_par;
        t_result    res;

        n_phase   = r_phase;
        n_wait    = r_wait;
        n_address = r_address;
        n_command = r_command;
        n_bes     = r_bes;
        n_data    = r_data;
        res       = '0;
        res.status = ST_OK;

        // The TRDY decision counts from the register value when DEVSEL just arrived.
        td_cnt  = (r_phase == PH_TRDY) ? r_wait : i_trdy_timeout;
        exp_par = (^r_data) ^ (^r_bes);

        unique case (r_phase)
            PH_ADDR: begin
                res.frame_out  = 1'b1;
                res.idsel_out  = 1'b1;
                res.ad_enable  = 1'b1;
                res.ad_out     = r_address;
                res.cbe_enable = 1'b1;
                res.cbe_out    = r_command;
                n_wait         = {4'd0, i_devsel_timeout};
                n_phase        = PH_TURN;
            end
            PH_TURN, PH_DEVSEL, PH_TRDY: begin
                res.irdy_out   = 1'b1;
                res.cbe_enable = 1'b1;
                res.cbe_out    = r_bes;
                if (r_phase == PH_TURN) begin
                    res.par_enable = 1'b1;
                    res.par_out    = (^r_address) ^ (^r_command);
                end
                if (r_phase != PH_TRDY && !i_sample.devsel_in) begin
                    if (r_wait <= 8'd1) begin
                        n_wait  = '0;
                        n_phase = PH_END_MASTER;
                    end else begin
                        n_wait  = r_wait - 8'd1;
                        n_phase = PH_DEVSEL;
                    end
                end else begin
                    n_wait = td_cnt;
                    if (i_sample.trdy_in) begin
                        n_data  = i_sample.ad_in;
                        n_phase = PH_DATA1;
                    end else if (i_sample.stop_in) begin
                        n_phase = i_sample.devsel_in ? PH_END_RETRY : PH_END_TARGET;
                    end else if (td_cnt <= 8'd1) begin
                        n_wait  = '0;
                        n_phase = PH_END_TRDY;
                    end else begin
                        n_wait  = td_cnt - 8'd1;
                        n_phase = PH_TRDY;
                    end
                end
            end
            PH_END_MASTER, PH_END_TRDY, PH_END_TARGET, PH_END_RETRY: begin
                res.done_res  = 1'b1;
                res.read_data = ALL_ONES;
                if (i_sample.devsel_in || i_sample.trdy_in) begin
                    res.status = ST_PROTO;
                end else if (r_phase == PH_END_MASTER) begin
                    res.status = ST_MASTER;
                end else if (r_phase == PH_END_TRDY) begin
                    res.status = ST_TRDY;
                end else if (r_phase == PH_END_TARGET) begin
                    res.status = ST_TARGET;
                end else begin
                    res.status = ST_RETRY;
                end
                n_phase = PH_IDLE;
            end
            PH_DATA1: begin
                n_phase = (i_sample.par_in != exp_par) ? PH_DATA_BAD : PH_DATA_OK;
            end
            PH_DATA_OK, PH_DATA_BAD: begin
                res.done_res = 1'b1;
                if (r_phase == PH_DATA_BAD) begin
                    res.status    = ST_PARITY;
                    res.read_data = r_data;
                end else if (i_sample.devsel_in || i_sample.trdy_in) begin
                    res.status    = ST_PROTO;
                    res.read_data = ALL_ONES;
                end else begin
                    res.read_data = r_data;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_sample.start_req) begin
                    if (i_sample.frame_in || i_sample.irdy_in) begin
                        // Someone else owns the bus: report it and stay idle.
                        res.done_res  = 1'b1;
                        res.status    = ST_PROTO;
                        res.read_data = ALL_ONES;
                    end else begin
                        n_address = i_sample.address;
                        n_command = i_sample.command;
                        n_bes     = i_sample.byte_enables;
                        n_phase   = PH_ADDR;
                    end
                end
            end
        endcase

        o_result = res;
    end

endmodule
